// ----- sv/assert_macros.svh -----
// assertion macros for the matrix inverse unit
// no dependencies; included by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ----- sv/mi3_pkg.sv -----
// shared constants, types and index tables for the 3x3 matrix inverse unit
// no dependencies
package mi3_pkg;
  localparam int FRAC_BITS = 16;
  localparam int EW    = 32;
  localparam int PW    = 2 * EW;
  localparam int AW    = PW + 1;
  localparam int DETW  = AW + EW + 2;
  localparam int MAGW  = DETW - 1;
  localparam int AMAGW = AW;
  localparam int DVW   = MAGW + 1;
  localparam int QW    = 34;
  localparam int RW    = DVW + QW;
  localparam int NSH   = 2 * FRAC_BITS + 1;

  // flat element index = 3 * column + row, cofactor i = a*b - c*d
  localparam logic [3:0] COF_A [9] = '{4'd4, 4'd6, 4'd3, 4'd7, 4'd0, 4'd6, 4'd1, 4'd3, 4'd0};
  localparam logic [3:0] COF_B [9] = '{4'd8, 4'd5, 4'd7, 4'd2, 4'd8, 4'd1, 4'd5, 4'd2, 4'd4};
  localparam logic [3:0] COF_C [9] = '{4'd7, 4'd3, 4'd6, 4'd1, 4'd6, 4'd0, 4'd4, 4'd0, 4'd3};
  localparam logic [3:0] COF_D [9] = '{4'd5, 4'd8, 4'd4, 4'd8, 4'd2, 4'd7, 4'd2, 4'd5, 4'd1};
  // row 0 elements and the cofactors they pair with for the determinant
  localparam logic [3:0] DET_M [3] = '{4'd0, 4'd3, 4'd6};
  localparam logic [3:0] DET_C [3] = '{4'd0, 4'd3, 4'd6};

  typedef logic [8:0][EW-1:0] mat_t;

  typedef struct packed {
    logic                  valid;
    logic                  sing;
    logic                  det_neg;
    logic [MAGW-1:0]       dmag;
    logic [8:0]            adj_neg;
    logic [8:0][AMAGW-1:0] amag;
  } front_t;

  typedef struct packed {
    logic          valid;
    logic          sing;
    logic          sat;
    logic [EW-1:0] elem;
  } lane_out_t;
endpackage

// ----- sv/matrix_inverse_3x3_unit.sv -----
// 3x3 matrix inverse by the adjugate, signed fixed point, one matrix a cycle
// while the skid word is empty. Nine division lanes work side by side, one
// per inverse element, fed by a shared cofactor and determinant pipeline;
// merge logic joins their flags. Data passes the cofactor and determinant
// stages, the bit-per-stage divider lanes and one output register. A skid
// word behind the output register catches a result that arrives while the
// output stalls; input ready drops while it is full. Depends on mi3_pkg,
// mi3_front, mi3_div_lane and assert_macros.svh.
`include "assert_macros.svh"
module matrix_inverse_3x3_unit import mi3_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,  // r0c0 r1c0 r2c0 r0c1 r1c1 r2c1 r0c2 r1c2 r2c2
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [287:0] m_axis_tdata,  // inv_r0c0 inv_r0c1 .. inv_r2c2, row by row
  output logic [1:0]   m_axis_tuser   // singular saturated
);
  logic      en;
  front_t    fr;
  lane_out_t lo [9];
  logic         f_valid;
  logic [287:0] f_data;
  logic [1:0]   f_user;
  logic         skid_v;
  logic [287:0] skid_data;
  logic [1:0]   skid_user;
  logic [8:0]   sats;

  assign en = !skid_v;
  assign s_axis_tready = en;

  mi3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .in_m     (s_axis_tdata),
    .out      (fr)
  );

  for (genvar i = 0; i < 9; i++) begin : g_lane
    mi3_div_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (fr.valid),
      .in_sing  (fr.sing),
      .in_neg   (fr.adj_neg[i] ^ fr.det_neg),
      .in_amag  (fr.amag[i]),
      .in_dmag  (fr.dmag),
      .out      (lo[i])
    );
    assign f_data[EW*i +: EW] = lo[i].elem;
    assign sats[i] = lo[i].sat;
  end

  // merge
  assign f_valid = lo[0].valid;
  assign f_user  = {|sats, lo[0].sing};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_v        <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_v) begin
        m_axis_tvalid <= 1'b1;
        skid_v        <= 1'b0;
      end else begin
        m_axis_tvalid <= f_valid;
      end
    end else if (f_valid && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tdata <= skid_v ? skid_data : f_data;
      m_axis_tuser <= skid_v ? skid_user : f_user;
    end else if (f_valid && en) begin
      skid_data <= f_data;
      skid_user <= f_user;
    end
  end

  `ASSERT_PROP(a_skid_behind_out, clk, rst, skid_v |-> m_axis_tvalid)
  `ASSERT_NEVER(a_sing_not_sat, clk, rst, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1])
  `ASSERT_PROP(a_sing_zero, clk, rst, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
  `ASSERT_PROP(a_stall_fills_skid, clk, rst, (m_axis_tvalid && !m_axis_tready && f_valid && !skid_v) |=> skid_v)
endmodule

// ----- sv/mi3_front.sv -----
// cofactor and determinant pipeline: nine cofactors, determinant, magnitudes
// depends on mi3_pkg
module mi3_front import mi3_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  mat_t   in_m,
  output front_t out
);
  logic [5:0] v;
  logic signed [PW-1:0]   pa [9];
  logic signed [PW-1:0]   pb [9];
  logic signed [EW-1:0]   m0a [3];
  logic signed [EW-1:0]   m0b [3];
  logic signed [AW-1:0]   adj2 [9];
  logic signed [AW-1:0]   adj3 [9];
  logic signed [AW-1:0]   adj4 [9];
  logic signed [AW-1:0]   adj5 [9];
  logic signed [AW-1:0]   pl [3];
  logic signed [AW-1:0]   ph [3];
  logic signed [DETW-1:0] term [3];
  logic signed [DETW-1:0] det;
  logic                   sing;
  logic                   det_neg;
  logic [MAGW-1:0]        dmag;
  logic [8:0]             adj_neg;
  logic [8:0][AMAGW-1:0]  amag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        pa[i] <= $signed(in_m[COF_A[i]]) * $signed(in_m[COF_B[i]]);
        pb[i] <= $signed(in_m[COF_C[i]]) * $signed(in_m[COF_D[i]]);
        adj2[i] <= AW'(pa[i]) - AW'(pb[i]);
        adj3[i] <= adj2[i];
        adj4[i] <= adj3[i];
        adj5[i] <= adj4[i];
      end
      for (int j = 0; j < 3; j++) begin
        m0a[j]  <= $signed(in_m[DET_M[j]]);
        m0b[j]  <= m0a[j];
        pl[j]   <= m0b[j] * $signed({1'b0, adj2[DET_C[j]][EW-1:0]});
        ph[j]   <= m0b[j] * $signed(adj2[DET_C[j]][AW-1:EW]);
        term[j] <= (DETW'(ph[j]) <<< EW) + DETW'(pl[j]);
      end
      det     <= term[0] + term[1] + term[2];
      sing    <= (det == '0);
      det_neg <= det[DETW-1];
      dmag    <= det[DETW-1] ? MAGW'(-det) : MAGW'(det);
      for (int i = 0; i < 9; i++) begin
        adj_neg[i] <= adj5[i][AW-1];
        amag[i]    <= adj5[i][AW-1] ? AMAGW'(-adj5[i]) : AMAGW'(adj5[i]);
      end
    end
  end

  always_comb begin
    out.valid   = v[5];
    out.sing    = sing;
    out.det_neg = det_neg;
    out.dmag    = dmag;
    out.adj_neg = adj_neg;
    out.amag    = amag;
  end
endmodule

// ----- sv/mi3_div_lane.sv -----
// one division lane: rounded quotient of a cofactor by the determinant,
// one quotient bit per stage, then saturation; depends on mi3_pkg
module mi3_div_lane import mi3_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic             in_sing,
  input  logic             in_neg,
  input  logic [AMAGW-1:0] in_amag,
  input  logic [MAGW-1:0]  in_dmag,
  output lane_out_t        out
);
  logic [QW:0]   v;
  logic [QW:0]   sg;
  logic [QW:0]   ng;
  logic [RW-1:0] rem [QW+1];
  logic [DVW-1:0] dv [QW+1];
  logic [QW-1:0] qb [QW+1];
  logic [EW-1:0] lim;
  logic          sat;
  logic [EW-1:0] mag;
  lane_out_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= (RW'(in_amag) << NSH) + RW'(in_dmag);
      dv[0]  <= {in_dmag, 1'b0};
      qb[0]  <= '0;
      sg[0]  <= in_sing;
      ng[0]  <= in_neg;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [RW-1:0] shd;
    logic          hit;
    assign shd = RW'(dv[s-1]) << (QW - s);
    assign hit = (rem[s-1] >= shd);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= hit ? rem[s-1] - shd : rem[s-1];
        dv[s]  <= dv[s-1];
        qb[s]  <= {qb[s-1][QW-2:0], hit};
        sg[s]  <= sg[s-1];
        ng[s]  <= ng[s-1];
      end
    end
  end

  always_comb begin
    lim = ng[QW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    sat = !sg[QW] && (qb[QW] > QW'(lim));
    mag = sat ? lim : qb[QW][EW-1:0];
    res.valid = v[QW];
    res.sing  = sg[QW];
    res.sat   = sat;
    if (sg[QW]) begin
      res.elem = '0;
    end else begin
      res.elem = ng[QW] ? -mag : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.sing <= res.sing;
      out.sat  <= res.sat;
      out.elem <= res.elem;
    end
  end
endmodule
